@@ rtl/utfd_pkg.sv @@
package utfd_pkg;

  // Field widths
  localparam int CP_W   = 21;
  localparam int USED_W = 3;
  localparam int BYTE_W = 8;

  // Decode constants
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
  localparam logic [9:0]      SURROGATE_TAG  = 10'h01B;
  localparam logic [1:0]      CONT_TAG       = 2'b10;

  // Sequence lengths
  localparam logic [USED_W-1:0] LEN_NONE = 3'd0;
  localparam logic [USED_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [USED_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [USED_W-1:0] LEN_THREE = 3'd3;
  localparam logic [USED_W-1:0] LEN_FOUR = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic              bad_sequence;
    logic [USED_W-1:0] bytes_used;
    logic              last_of_run;
  } result_t;

  // One queue entry: the results caused by one input byte (one or two)
  typedef struct packed {
    logic    two;
    result_t res_a;
    result_t res_b;
  } entry_t;

  // Sequence length from the lead byte's top five bits; LEN_NONE is invalid
  function automatic logic [USED_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
    logic [USED_W-1:0] len;
    if (b[7] == 1'b0)            len = LEN_ONE;
    else if (b[7:5] == 3'b110)   len = LEN_TWO;
    else if (b[7:4] == 4'b1110)  len = LEN_THREE;
    else if (b[7:3] == 5'b11110) len = LEN_FOUR;
    else                         len = LEN_NONE;
    return len;
  endfunction

  // Payload bits carried by a lead byte
  function automatic logic [CP_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                input logic [USED_W-1:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      LEN_TWO:   v = {16'd0, b[4:0]};
      LEN_THREE: v = {17'd0, b[3:0]};
      LEN_FOUR:  v = {18'd0, b[2:0]};
      default:   v = {14'd0, b[6:0]};
    endcase
    return v;
  endfunction

  // Smallest value that is not overlong for a given length
  function automatic logic [CP_W-1:0] min_value(input logic [USED_W-1:0] len);
    logic [CP_W-1:0] v;
    unique case (len)
      LEN_TWO:   v = 21'h000080;
      LEN_THREE: v = 21'h000800;
      LEN_FOUR:  v = 21'h010000;
      default:   v = 21'h000000;
    endcase
    return v;
  endfunction

  function automatic result_t bad_result(input logic [USED_W-1:0] used, input logic last);
    result_t r;
    r.code_point   = REPLACEMENT_CP;
    r.bad_sequence = 1'b1;
    r.bytes_used   = used;
    r.last_of_run  = last;
    return r;
  endfunction

endpackage

@@ rtl/utfd_byte_if.sv @@
interface utfd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [utfd_pkg::BYTE_W-1:0]    text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

@@ rtl/utfd_result_if.sv @@
interface utfd_result_if;
  logic                           valid;
  logic                           ready;
  logic [utfd_pkg::CP_W-1:0]      code_point;
  logic                           bad_sequence;
  logic [utfd_pkg::USED_W-1:0]    bytes_used;
  logic                           last_of_run;

  modport source (output valid, output code_point, output bad_sequence,
                  output bytes_used, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input bad_sequence,
                  input bytes_used, input last_of_run, output ready);
endinterface

@@ rtl/utfd_front.sv @@
module utfd_front (
  input  logic                clk,
  input  logic                rst,
  utfd_byte_if.sink           text,
  input  logic                full,
  output logic                push,
  output utfd_pkg::entry_t    entry
);

  logic [utfd_pkg::USED_W-1:0] expected_length, expected_length_next;
  logic [utfd_pkg::USED_W-1:0] bytes_seen, bytes_seen_next;
  logic [utfd_pkg::CP_W-1:0]   partial_value, partial_value_next;

  logic [utfd_pkg::BYTE_W-1:0] b;
  logic                        take;
  logic [utfd_pkg::USED_W-1:0] lead_len;
  logic                        lead_starts;
  utfd_pkg::result_t           lead_res;
  logic [utfd_pkg::CP_W-1:0]   shifted;
  logic [utfd_pkg::USED_W-1:0] seen_inc;
  logic                        done_bad;

  assign text.ready = !full;
  assign take       = text.valid && text.ready;
  assign b          = text.text_byte;

  // Lead byte classification
  always_comb begin
    lead_len    = utfd_pkg::lead_length(b);
    lead_starts = (lead_len != utfd_pkg::LEN_NONE) && (lead_len != utfd_pkg::LEN_ONE);
    if (lead_len == utfd_pkg::LEN_NONE) begin
      lead_res = utfd_pkg::bad_result(utfd_pkg::LEN_ONE, 1'b1);
    end else begin
      lead_res.code_point   = utfd_pkg::lead_bits(b, utfd_pkg::LEN_ONE);
      lead_res.bad_sequence = 1'b0;
      lead_res.bytes_used   = utfd_pkg::LEN_ONE;
      lead_res.last_of_run  = 1'b1;
    end
  end

  // Continuation step and final value checks
  always_comb begin
    shifted  = {partial_value[utfd_pkg::CP_W-7:0], b[5:0]};
    seen_inc = bytes_seen + utfd_pkg::USED_W'(1);
    done_bad = (shifted > utfd_pkg::MAX_SCALAR) ||
               (shifted[utfd_pkg::CP_W-1:11] == utfd_pkg::SURROGATE_TAG) ||
               (shifted < utfd_pkg::min_value(expected_length));
  end

  // Sequence tracking and result building
  always_comb begin
    expected_length_next = expected_length;
    bytes_seen_next      = bytes_seen;
    partial_value_next   = partial_value;
    push                 = 1'b0;
    entry.two            = 1'b0;
    entry.res_a          = lead_res;
    entry.res_b          = lead_res;
    if (take) begin
      if (expected_length == utfd_pkg::LEN_NONE) begin
        if (lead_starts) begin
          expected_length_next = lead_len;
          bytes_seen_next      = utfd_pkg::LEN_ONE;
          partial_value_next   = utfd_pkg::lead_bits(b, lead_len);
        end else begin
          push = 1'b1;
        end
      end else if (b[7:6] == utfd_pkg::CONT_TAG) begin
        bytes_seen_next    = seen_inc;
        partial_value_next = shifted;
        if (seen_inc >= expected_length) begin
          push = 1'b1;
          entry.res_a.code_point   = done_bad ? utfd_pkg::REPLACEMENT_CP : shifted;
          entry.res_a.bad_sequence = done_bad;
          entry.res_a.bytes_used   = expected_length;
          entry.res_a.last_of_run  = 1'b1;
          expected_length_next     = utfd_pkg::LEN_NONE;
          bytes_seen_next          = '0;
          partial_value_next       = '0;
        end
      end else begin
        // Truncated sequence, then the breaking byte opens a new sequence or gives its own result
        push        = 1'b1;
        entry.res_a = utfd_pkg::bad_result(bytes_seen, !lead_starts ? 1'b0 : 1'b1);
        if (lead_starts) begin
          expected_length_next = lead_len;
          bytes_seen_next      = utfd_pkg::LEN_ONE;
          partial_value_next   = utfd_pkg::lead_bits(b, lead_len);
        end else begin
          entry.two            = 1'b1;
          expected_length_next = utfd_pkg::LEN_NONE;
          bytes_seen_next      = '0;
          partial_value_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= utfd_pkg::LEN_NONE;
      bytes_seen      <= '0;
      partial_value   <= '0;
    end else begin
      expected_length <= expected_length_next;
      bytes_seen      <= bytes_seen_next;
      partial_value   <= partial_value_next;
    end
  end

endmodule

@@ rtl/utfd_queue.sv @@
module utfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utfd_pkg::entry_t wr_data,
  output logic             full,
  input  logic             pop,
  output utfd_pkg::entry_t rd_data,
  output logic             empty
);

  utfd_pkg::entry_t                slots [utfd_pkg::QUEUE_DEPTH];
  logic [utfd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [utfd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [utfd_pkg::QPTR_W-1:0]     rd_ptr_next;
  logic [utfd_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full        = (count == utfd_pkg::QCNT_W'(utfd_pkg::QUEUE_DEPTH));
  assign empty       = (count == '0);
  assign do_push     = push && !full;
  assign do_pop      = pop && !empty;
  assign rd_ptr_next = do_pop ? rd_ptr + utfd_pkg::QPTR_W'(1) : rd_ptr;

  // Entry storage; the head is read ahead into the registered read port, and an entry written
  // into the next head slot is forwarded straight to the read register
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= slots[rd_ptr_next];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + utfd_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + utfd_pkg::QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + utfd_pkg::QCNT_W'(1);
        2'b01:   count <= count - utfd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/utfd_back.sv @@
module utfd_back (
  input  logic             clk,
  input  logic             rst,
  input  utfd_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  utfd_result_if.source    decoded
);

  logic              hold_valid;
  utfd_pkg::entry_t  hold;
  logic              sel;
  logic              taken;
  logic              finished;
  logic              load;
  utfd_pkg::result_t cur;

  assign cur      = sel ? hold.res_b : hold.res_a;
  assign taken    = decoded.valid && decoded.ready;
  assign finished = taken && (sel || !hold.two);
  assign load     = !hold_valid || finished;
  assign pop      = load && !empty;

  assign decoded.valid        = hold_valid;
  assign decoded.code_point   = cur.code_point;
  assign decoded.bad_sequence = cur.bad_sequence;
  assign decoded.bytes_used   = cur.bytes_used;
  assign decoded.last_of_run  = cur.last_of_run;

  // Holding register: one entry, sent out one result per request
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (load) begin
      hold_valid <= !empty;
      sel        <= 1'b0;
    end else if (taken) begin
      sel <= 1'b1;
    end
  end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// UTF-8 stream decoder: takes one byte per request on text and returns decoded
// Unicode scalars on decoded, each with bad_sequence, bytes_used and last_of_run.
// A byte is accepted every clock while the four-entry result queue has room;
// a multi-byte sequence gives no result until its last byte, and a byte that
// breaks a pending sequence gives the error for the truncated sequence and,
// unless it opens a new sequence, its own result as well, which the output
// side sends after the error result is taken. Sustained throughput is one
// byte per clock while decoded is ready, limited by the output side's one
// result per clock. A result passes through the queue's read register and
// the output side's holding register. Invalid, truncated, overlong, surrogate
// and out-of-range sequences return code point 0xFFFD.
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  utfd_byte_if.sink     text,
  utfd_result_if.source decoded
);

  utfd_pkg::entry_t push_entry;
  utfd_pkg::entry_t head_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  utfd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  utfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (head_entry),
    .empty   (empty)
  );

  utfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head_entry),
    .empty   (empty),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

@@ rtl/utfd_checker.sv @@
module utfd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [utfd_pkg::CP_W-1:0]    code_point,
  input logic                         bad_sequence,
  input logic [utfd_pkg::USED_W-1:0]  bytes_used,
  input logic                         last_of_run
);

  // Reset clears the output side
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) &&
      $stable(bad_sequence) && $stable(bytes_used) && $stable(last_of_run))
    else $error("stalled result changed");

  // Error results carry the replacement character
  a_bad_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_sequence |-> code_point == utfd_pkg::REPLACEMENT_CP)
    else $error("error result without replacement code point");

  // Good results are scalars and consume one to four bytes
  a_good_scalar: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_sequence |-> code_point <= utfd_pkg::MAX_SCALAR &&
      code_point[utfd_pkg::CP_W-1:11] != utfd_pkg::SURROGATE_TAG &&
      bytes_used != utfd_pkg::LEN_NONE && bytes_used <= utfd_pkg::LEN_FOUR)
    else $error("good result is not a valid scalar");

  // A good single-byte result is ASCII and always ends its run
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_sequence && bytes_used == utfd_pkg::LEN_ONE |->
      code_point < 21'h000080 && last_of_run)
    else $error("single-byte result out of ASCII range");

endmodule

bind utf8_stream_decoder utfd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (decoded.valid),
  .out_ready    (decoded.ready),
  .code_point   (decoded.code_point),
  .bad_sequence (decoded.bad_sequence),
  .bytes_used   (decoded.bytes_used),
  .last_of_run  (decoded.last_of_run)
);
